>>> design/aes_pkg.sv
// Package for the AES-128 encryption pipeline: sizes, S-box, round functions
// and key expansion step. No dependencies.
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int BlockW    = 128;
    localparam int HalfW     = 64;
    localparam int RegIdxW   = 1;

    localparam logic [RegIdxW-1:0] RegKeyHigh = 1'b0;
    localparam logic [RegIdxW-1:0] RegKeyLow  = 1'b1;

    typedef logic [BlockW-1:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte n of a block sits in bits 127-8n down to 120-8n.
    function automatic logic [7:0] get_byte(input block_t b, input int n);
        return b[BlockW-1-8*n -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for round r, r from 1 to 10.
    function automatic logic [7:0] rcon(input int r);
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 1; i < r; i++) rc = gf_double(rc);
        return rc;
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BlockW-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);   a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
            d0 = gf_double(a0); d1 = gf_double(a1);
            d2 = gf_double(a2); d3 = gf_double(a3);
            t[BlockW-1-8*(4*c)   -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            t[BlockW-1-8*(4*c+1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            t[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            t[BlockW-1-8*(4*c+3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        return t;
    endfunction

    function automatic block_t next_round_key(input block_t rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = rk[127:96]; w1 = rk[95:64]; w2 = rk[63:32]; w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

>>> design/aes_round.sv
// One cipher round stage: round transform and on-the-fly key expansion,
// registered. Depends on aes_pkg.
module aes_round (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,      // the stage register loads this cycle
    input  logic [3:0]      round_num,    // constant per instance, 1 to 10
    input  logic            in_valid,
    input  aes_pkg::block_t in_state,
    input  aes_pkg::block_t in_key,
    output logic            out_valid,
    output aes_pkg::block_t out_state,
    output aes_pkg::block_t out_key
);

    aes_pkg::block_t state_reg, state_next, key_reg, key_next, shifted;
    logic            valid_reg;
    logic [7:0]      rc;

    always_comb begin
        rc = 8'h01;
        for (int i = 1; i < aes_pkg::NumRounds; i++)
            if (4'(i) < round_num) rc = aes_pkg::gf_double(rc);
        key_next   = aes_pkg::next_round_key(in_key, rc);
        shifted    = aes_pkg::sub_shift(in_state);
        state_next = ((round_num == 4'(aes_pkg::NumRounds)) ? shifted
                      : aes_pkg::mix_columns(shifted)) ^ key_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

>>> design/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 ECB encryptor: key registers, initial
// key addition and ten round stages. Depends on aes_pkg, aes_round.
//
//  Channel   Direction  Payload
//  s_axis    in         block_high, block_low (plaintext)
//  m_axis    out        cipher_high, cipher_low (ciphertext)
//  cfg       in         key_high (index 0), key_low (index 1)
//
// One block is accepted per cycle while the pipeline advances. A block passes
// one register stage for the initial key addition and one per round.
// The key travels down the pipeline with each block, so a key written
// between blocks applies to every later block. Reset (aresetn low, synchronous)
// clears all valid bits and both key registers. When m_tready is low the whole
// pipeline holds unless its final stage is empty; nothing is lost or repeated.
module aes128_block_encrypt (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // [63:0] block_high, [127:64] block_low
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // [63:0] cipher_high, [127:64] cipher_low
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    localparam int N = aes_pkg::NumRounds;

    logic [63:0] key_high_reg, key_low_reg;
    logic        advance;

    // Stage 0 holds the initial AddRoundKey result; stages 1..N are rounds.
    logic            v   [N+1];
    aes_pkg::block_t st  [N+1];
    aes_pkg::block_t ky  [N+1];
    logic            v0_reg;
    aes_pkg::block_t st0_reg, ky0_reg, key_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                aes_pkg::RegKeyHigh: key_high_reg <= cfg_data;
                aes_pkg::RegKeyLow:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together; it stalls only when a result waits.
    assign advance  = m_tready || !v[N];
    assign s_tready = advance;
    assign key_in   = {key_high_reg, key_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (advance) begin
            v0_reg <= s_tvalid;
        end
        if (advance) begin
            st0_reg <= {s_tdata[63:0], s_tdata[127:64]} ^ key_in;
            ky0_reg <= key_in;
        end
    end

    assign v[0]  = v0_reg;
    assign st[0] = st0_reg;
    assign ky[0] = ky0_reg;

    for (genvar r = 1; r <= N; r++) begin : g_round
        aes_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .round_num (4'(r)),
            .in_valid  (v[r-1]),
            .in_state  (st[r-1]),
            .in_key    (ky[r-1]),
            .out_valid (v[r]),
            .out_state (st[r]),
            .out_key   (ky[r])
        );
    end

    assign m_tvalid = v[N];
    assign m_tdata  = {st[N][63:0], st[N][127:64]};

    // A stalled result must hold its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input is refused only while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without backpressure");

    // An accepted block reaches the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v0_reg)
        else $error("accepted block lost");

endmodule

>>> sim/aes128_block_encrypt_tb.sv
// Self-checking testbench for the pipelined AES-128 ECB encryptor. Blocks are
// streamed in and every ciphertext is compared with an in-bench cipher model.
// Depends on aes_pkg (register indexes) and aes128_block_encrypt.
module aes128_block_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  Latency    = 11;
    localparam longint CycleLimit = 400000;

    // Forward S-box used by the in-bench cipher.
    localparam logic [7:0] SubTable [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // [63:0] block_high, [127:64] block_low
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // [63:0] cipher_high, [127:64] cipher_low
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [63:0]  cfg_data;

    // The bench keeps its own copy of the key, updated on every write.
    logic [63:0] cur_key_high, cur_key_low;
    cipher_t     pending_ciphers[$];

    int     error_count;
    int     blocks_sent, ciphers_seen;
    int     send_idle_pct, recv_stall_pct;
    bit     hold_recv;
    longint cycle_count;

    aes128_block_encrypt dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .cfg_we, .cfg_index, .cfg_data
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypts one block under the current key. State bytes are held in an
    // array indexed column-major: byte n is row n mod 4, column n div 4.
    function automatic cipher_t encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0] st[16], rk[16], tmp[16], kt[4];
        logic [7:0] a0, a1, a2, a3, rc;
        cipher_t res;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            st[i]     = hi[63-8*i -: 8];
            st[8+i]   = lo[63-8*i -: 8];
            rk[i]     = cur_key_high[63-8*i -: 8];
            rk[8+i]   = cur_key_low[63-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r+4*c] = SubTable[st[r + 4*((c+r) % 4)]];
            st = tmp;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                    st[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                    st[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                    st[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
                end
            end
            // Key schedule: rotate and substitute the last word, add rcon to the first.
            kt[0] = SubTable[rk[13]] ^ rc;
            kt[1] = SubTable[rk[14]];
            kt[2] = SubTable[rk[15]];
            kt[3] = SubTable[rk[12]];
            for (int i = 0; i < 4; i++) rk[i] ^= kt[i];
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
            rc = xtime(rc);
            for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        end
        for (int i = 0; i < 8; i++) begin
            res.cipher_high[63-8*i -: 8] = st[i];
            res.cipher_low[63-8*i -: 8]  = st[8+i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random 64-bit value biased toward all-zero, all-one and single-bit patterns.
    function automatic logic [63:0] pick_word();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    // Writes one key register; the block is idle whenever this is called.
    // The enable drops for a cycle after each write.
    task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == aes_pkg::RegKeyHigh) cur_key_high = value;
        else cur_key_low = value;
        @(posedge aclk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        write_key(aes_pkg::RegKeyHigh, hi);
        write_key(aes_pkg::RegKeyLow, lo);
    endtask

    // Offers one block, with an optional random idle gap first, and records
    // the ciphertext that must come back for it once the transfer is taken.
    // Valid stays high afterwards so that blocks can follow back to back.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_ciphers.push_back(encrypt_block(hi, lo));
        blocks_sent++;
    endtask

    // Stops offering, waits until every expected ciphertext has come back,
    // then lets the pipeline drain fully before any key write.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_ciphers.size() != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
    endtask

    task automatic test_known_vectors();
        // The standard FIPS-197 key-expansion example.
        load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain_pipeline();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain_pipeline();
    endtask

    task automatic test_extreme_values();
        logic [63:0] corners[4];
        corners = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000001, 64'h5555aaaa5555aaaa};
        for (int k = 0; k < 4; k++) begin
            load_key(corners[k], corners[3-k]);
            for (int b = 0; b < 4; b++) send_block(corners[b], corners[(b+k) % 4]);
            drain_pipeline();
        end
    endtask

    // A key change must apply from the very next block only.
    task automatic test_key_change();
        load_key(rand64(), rand64());
        for (int i = 0; i < 3; i++) send_block(rand64(), rand64());
        drain_pipeline();
        write_key(aes_pkg::RegKeyLow, rand64());
        send_block(64'h0, 64'h0);
        drain_pipeline();
        write_key(aes_pkg::RegKeyHigh, rand64());
        send_block(64'h0, 64'h0);
        drain_pipeline();
    endtask

    task automatic test_random_blocks(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_key(pick_word(), pick_word());
        for (int i = 0; i < count; i++) begin
            send_block(pick_word(), pick_word());
            // Each run switches key after every 120 blocks.
            if (i % 120 == 119) begin
                drain_pipeline();
                load_key(pick_word(), pick_word());
            end
        end
        drain_pipeline();
    endtask

    // The receiver refuses everything for a long stretch while blocks keep
    // coming, so the pipeline fills and pushes back on the sender.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b1;
        for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
        drain_pipeline();
    endtask

    // Receiver hold-off counted in cycles of its own.
    always @(posedge aclk) begin
        if (hold_recv) begin
            repeat (200) @(posedge aclk);
            hold_recv <= 1'b0;
        end
    end

    // Ready pattern of the receiver.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Checks every ciphertext transfer against the oldest expectation.
    always @(posedge aclk) begin
        cipher_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[63:0], m_tdata[127:64]};
            ciphers_seen++;
            if (pending_ciphers.size() == 0) begin
                $error("unexpected cipher block %h", m_tdata);
                error_count++;
            end else begin
                want = pending_ciphers.pop_front();
                if (got.cipher_high !== want.cipher_high) begin
                    $error("cipher_high: expected %h, got %h", want.cipher_high, got.cipher_high);
                    error_count++;
                end
                if (got.cipher_low !== want.cipher_low) begin
                    $error("cipher_low: expected %h, got %h", want.cipher_low, got.cipher_low);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("aes128_block_encrypt_tb: errors");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cur_key_high   = '0;
        cur_key_low    = '0;
        error_count    = 0;
        blocks_sent    = 0;
        ciphers_seen   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_recv      = 1'b0;
        cycle_count    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Right after reset the key is all zeros.
        send_block(64'h0, 64'h0);
        drain_pipeline();
        test_known_vectors();
        test_extreme_values();
        test_key_change();
        test_backpressure();
        test_random_blocks(500, 0, 0);
        test_random_blocks(450, 52, 0);
        test_random_blocks(450, 0, 52);
        test_random_blocks(450, 24, 24);

        $display("covered %0d blocks and %0d ciphertexts across key changes,",
                 blocks_sent, ciphers_seen);
        $display("idle, stall and long back-pressure phases");
        if (error_count == 0) begin
            $display("aes128_block_encrypt_tb: clean");
        end else begin
            $display("aes128_block_encrypt_tb: errors");
        end
        $finish;
    end
endmodule
